@@ rtl/core/ihs_pkg.sv @@
package ihs_pkg;

	typedef enum logic [1:0] {
		KIND_UNKNOWN,
		KIND_GIF,
		KIND_JPEG,
		KIND_PNG
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_TOO_SHORT,
		STATUS_UNKNOWN_SIG,
		STATUS_NO_FRAME
	} status_t;

	typedef enum logic [1:0] {
		SCAN_FF,
		SCAN_MARKER,
		SCAN_CAPTURE,
		SCAN_DONE
	} scan_t;

	typedef struct packed {
		logic png;
		logic jpeg;
		logic gif;
	} sig_flags_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} in_word_t;

	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic [15:0] width;
		logic [15:0] height;
	} result_t;

	localparam logic [4:0] COUNT_MAX       = 5'd24;
	localparam logic [4:0] JPEG_MIN_LEN    = 5'd20;
	localparam logic [4:0] GIF_MIN_LEN     = 5'd6;
	localparam logic [4:0] MIN_LEN         = 5'd4;
	localparam logic [4:0] GIF_SIG_LEN     = 5'd4;
	localparam logic [4:0] JPEG_SIG_LEN    = 5'd3;
	localparam logic [4:0] PNG_SIG_LEN     = 5'd8;
	localparam logic [4:0] JPEG_SCAN_START = 5'd2;

	localparam logic [4:0] PNG_WIDTH_HI  = 5'd18;
	localparam logic [4:0] PNG_WIDTH_LO  = 5'd19;
	localparam logic [4:0] PNG_HEIGHT_HI = 5'd22;
	localparam logic [4:0] PNG_HEIGHT_LO = 5'd23;

	localparam logic [2:0] CAP_HEIGHT_HI = 3'd3;
	localparam logic [2:0] CAP_HEIGHT_LO = 3'd4;
	localparam logic [2:0] CAP_WIDTH_HI  = 3'd5;
	localparam logic [2:0] CAP_WIDTH_LO  = 3'd6;

	localparam logic [7:0] MARKER_PREFIX = 8'hFF;
	localparam logic [7:0] SOF_FIRST     = 8'hC0;
	localparam logic [7:0] SOF_LAST      = 8'hC3;

	localparam logic [7:0] GIF_SIG [4] = '{8'h47, 8'h49, 8'h46, 8'h38};
	localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
		8'h0D, 8'h0A, 8'h1A, 8'h0A};

	function automatic logic [7:0] jpeg_sig_byte(input logic [1:0] idx);
		logic [7:0] sig;
		case (idx)
			2'd0:    sig = 8'hFF;
			2'd1:    sig = 8'hD8;
			2'd2:    sig = 8'hFF;
			default: sig = 8'h00;
		endcase
		return sig;
	endfunction

endpackage

@@ rtl/core/ihs_in_stage.sv @@
module ihs_in_stage
	import ihs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] byte_value,
	input  logic       last_byte,
	output logic       byte_stall,
	input  logic       advance,
	output logic       valid_s1,
	output in_word_t   word_s1
);

	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			word_s1 <= '{value: byte_value, last: last_byte};
		end
	end

endmodule

@@ rtl/core/ihs_core.sv @@
module ihs_core
	import ihs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_word_t word_s1,
	output result_t  result
);

	logic [4:0]  count_q, count_n;
	sig_flags_t  flags_q, flags_n;
	scan_t       scan_q, scan_n;
	logic [2:0]  cap_q, cap_n;
	logic        found_q, found_n;
	logic [15:0] width_q, width_n;
	logic [15:0] height_q, height_n;
	logic        cap_write;
	logic [7:0]  b;

	assign b = word_s1.value;

	always_comb begin
		flags_n = flags_q;
		if (count_q < GIF_SIG_LEN && b != GIF_SIG[count_q[1:0]]) begin
			flags_n.gif = 1'b0;
		end
		if (count_q < JPEG_SIG_LEN && b != jpeg_sig_byte(count_q[1:0])) begin
			flags_n.jpeg = 1'b0;
		end
		if (count_q < PNG_SIG_LEN && b != PNG_SIG[count_q[2:0]]) begin
			flags_n.png = 1'b0;
		end
	end

	always_comb begin
		count_n = (count_q < COUNT_MAX) ? count_q + 5'd1 : count_q;
	end

	// Marker scan: next state.
	always_comb begin
		scan_n    = scan_q;
		cap_n     = cap_q;
		found_n   = found_q;
		cap_write = 1'b0;
		if (count_q >= JPEG_SCAN_START) begin
			case (scan_q)
				SCAN_FF: begin
					if (b == MARKER_PREFIX) begin
						scan_n = SCAN_MARKER;
					end
				end
				SCAN_MARKER: begin
					if (b inside {[SOF_FIRST:SOF_LAST]}) begin
						scan_n = SCAN_CAPTURE;
						cap_n  = 3'd0;
					end else begin
						scan_n = SCAN_FF;
					end
				end
				SCAN_CAPTURE: begin
					cap_write = 1'b1;
					if (cap_q >= CAP_WIDTH_LO) begin
						found_n = 1'b1;
						scan_n  = SCAN_DONE;
					end else begin
						cap_n = cap_q + 3'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Dimension capture for both formats.
	always_comb begin
		width_n  = width_q;
		height_n = height_q;
		if (flags_n.png) begin
			case (count_q)
				PNG_WIDTH_HI:  width_n[15:8]  = b;
				PNG_WIDTH_LO:  width_n[7:0]   = b;
				PNG_HEIGHT_HI: height_n[15:8] = b;
				PNG_HEIGHT_LO: height_n[7:0]  = b;
				default: begin
				end
			endcase
		end
		if (cap_write && flags_n.jpeg) begin
			case (cap_q)
				CAP_HEIGHT_HI: height_n[15:8] = b;
				CAP_HEIGHT_LO: height_n[7:0]  = b;
				CAP_WIDTH_HI:  width_n[15:8]  = b;
				CAP_WIDTH_LO:  width_n[7:0]   = b;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		result = '{kind: KIND_UNKNOWN, status: STATUS_OK, width: 16'd0, height: 16'd0};
		if (count_n < MIN_LEN) begin
			result.status = STATUS_TOO_SHORT;
		end else if (flags_n.gif) begin
			if (count_n >= GIF_MIN_LEN) begin
				result.kind = KIND_GIF;
			end else begin
				result.status = STATUS_TOO_SHORT;
			end
		end else if (flags_n.jpeg) begin
			result.kind = KIND_JPEG;
			if (count_n < JPEG_MIN_LEN) begin
				result.status = STATUS_TOO_SHORT;
			end else if (found_n) begin
				result.width  = width_n;
				result.height = height_n;
			end else begin
				result.status = STATUS_NO_FRAME;
			end
		end else if (flags_n.png) begin
			if (count_n < PNG_SIG_LEN) begin
				result.status = STATUS_TOO_SHORT;
			end else if (count_n < COUNT_MAX) begin
				result.kind   = KIND_PNG;
				result.status = STATUS_TOO_SHORT;
			end else begin
				result.kind   = KIND_PNG;
				result.width  = width_n;
				result.height = height_n;
			end
		end else begin
			result.status = STATUS_UNKNOWN_SIG;
		end
	end

	// The state returns to its reset value after the last word of a file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 5'd0;
			flags_q  <= '1;
			scan_q   <= SCAN_FF;
			cap_q    <= 3'd0;
			found_q  <= 1'b0;
			width_q  <= 16'd0;
			height_q <= 16'd0;
		end else if (step) begin
			if (word_s1.last) begin
				count_q  <= 5'd0;
				flags_q  <= '1;
				scan_q   <= SCAN_FF;
				cap_q    <= 3'd0;
				found_q  <= 1'b0;
				width_q  <= 16'd0;
				height_q <= 16'd0;
			end else begin
				count_q  <= count_n;
				flags_q  <= flags_n;
				scan_q   <= scan_n;
				cap_q    <= cap_n;
				found_q  <= found_n;
				width_q  <= width_n;
				height_q <= height_n;
			end
		end
	end

endmodule

@@ rtl/core/ihs_out_stage.sv @@
module ihs_out_stage
	import ihs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  result_t     result_in,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  image_kind,
	output logic [1:0]  status,
	output logic [15:0] width,
	output logic [15:0] height
);

	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_in;
		end
	end

	assign image_kind = result_q.kind;
	assign status     = result_q.status;
	assign width      = result_q.width;
	assign height     = result_q.height;

endmodule

@@ rtl/core/image_header_sniffer_top.sv @@
// Identifies a GIF, JPEG or PNG file from its bytes, taken one word per cycle, and gives one
// result word (format, status, width, height) for the word marked as the last of the file; other
// words give no result. A word enters the input register, and once it advances it is folded into
// the running header state while, for a last word, the result is loaded into the output register.
// One word can be accepted in every cycle; the input side stalls only while a last word waits
// behind an output result that is itself stalled. After each result the header state clears
// itself for the next file.
module image_header_sniffer_top
	import ihs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  image_kind,
	output logic [1:0]  status,
	output logic [15:0] width,
	output logic [15:0] height
);

	logic     valid_s1;
	in_word_t word_s1;
	logic     advance;
	logic     load;
	result_t  result;

	assign advance = valid_s1 && (!word_s1.last || !result_valid || !result_stall);
	assign load    = advance && word_s1.last;

	ihs_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.byte_stall (byte_stall),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.word_s1    (word_s1)
	);

	ihs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.word_s1 (word_s1),
		.result  (result)
	);

	ihs_out_stage u_out_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.result_in    (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.image_kind   (image_kind),
		.status       (status),
		.width        (width),
		.height       (height)
	);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> result_valid)
		else $error("last word did not produce a result");

	assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && word_s1.last && result_valid)
		else $error("input stalled without a waiting last word");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != STATUS_OK |-> width == 16'd0 && height == 16'd0)
		else $error("dimensions given with a failing status");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && image_kind == KIND_GIF |-> width == 16'd0 && height == 16'd0)
		else $error("GIF result carries dimensions");
`endif

endmodule
